// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file tps_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tps_pkg.sv
`default_nettype none

package tps_pkg;

  localparam int unsigned MaxSteps = 12;
  localparam int unsigned HzW      = 12;
  localparam int unsigned MsW      = 9;
  localparam int unsigned StepW    = 4;
  localparam int unsigned PatW     = 3;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // request codes
  localparam logic ReqTick  = 1'b0;
  localparam logic ReqStart = 1'b1;

  // pattern codes
  localparam logic [PatW-1:0] PatSilent   = 3'd0;
  localparam logic [PatW-1:0] PatShort    = 3'd1;
  localparam logic [PatW-1:0] PatDouble   = 3'd2;
  localparam logic [PatW-1:0] PatError    = 3'd3;
  localparam logic [PatW-1:0] PatUrgent   = 3'd4;
  localparam logic [PatW-1:0] PatStartup  = 3'd5;
  localparam logic [PatW-1:0] PatSuccess  = 3'd6;
  localparam logic [PatW-1:0] PatSilentHi = 3'd7;

  // register index
  localparam logic [0:0] RegMute = 1'b0;

  typedef struct packed {
    logic            req_type;
    logic [PatW-1:0] pattern;
  } in_item_t;

  typedef struct packed {
    logic [HzW-1:0] tone_hz;
    logic           playing;
    logic           finished;
  } out_item_t;

  typedef struct packed {
    logic [HzW-1:0] hz;
    logic [MsW-1:0] ms;
  } tone_step_t;

  // step count of a pattern, capped at MaxSteps
  function automatic logic [StepW-1:0] eff_len(input logic [PatW-1:0] pat);
    logic [StepW-1:0] n;
    case (pat)
      PatShort:   n = 4'd2;
      PatDouble:  n = 4'd4;
      PatError:   n = 4'd2;
      PatUrgent:  n = 4'd12;
      PatStartup: n = 4'd6;
      PatSuccess: n = 4'd8;
      default:    n = 4'd0;
    endcase
    if (32'(n) > MaxSteps) begin
      n = StepW'(MaxSteps);
    end
    return n;
  endfunction

  // frequency and duration of one step
  function automatic tone_step_t step_lookup(input logic [PatW-1:0] pat,
                                             input logic [StepW-1:0] step);
    tone_step_t ts;
    ts = '0;
    case (pat)
      PatShort: begin
        case (step)
          4'd0:    ts = {12'd1047, 9'd100};
          4'd1:    ts = {12'd0, 9'd50};
          default: ts = '0;
        endcase
      end
      PatDouble: begin
        case (step)
          4'd0:    ts = {12'd1047, 9'd100};
          4'd1:    ts = {12'd0, 9'd80};
          4'd2:    ts = {12'd1047, 9'd100};
          4'd3:    ts = {12'd0, 9'd50};
          default: ts = '0;
        endcase
      end
      PatError: begin
        case (step)
          4'd0:    ts = {12'd400, 9'd300};
          4'd1:    ts = {12'd0, 9'd50};
          default: ts = '0;
        endcase
      end
      PatUrgent: begin
        case (step)
          4'd0, 4'd4, 4'd8:        ts = {12'd1000, 9'd80};
          4'd2, 4'd6, 4'd10:       ts = {12'd1500, 9'd80};
          4'd1, 4'd3, 4'd5, 4'd7, 4'd9:
                                   ts = {12'd0, 9'd40};
          4'd11:                   ts = {12'd0, 9'd50};
          default:                 ts = '0;
        endcase
      end
      PatStartup: begin
        case (step)
          4'd0:    ts = {12'd1047, 9'd150};
          4'd1:    ts = {12'd0, 9'd50};
          4'd2:    ts = {12'd1319, 9'd150};
          4'd3:    ts = {12'd0, 9'd50};
          4'd4:    ts = {12'd1568, 9'd300};
          4'd5:    ts = {12'd0, 9'd50};
          default: ts = '0;
        endcase
      end
      PatSuccess: begin
        case (step)
          4'd0:    ts = {12'd1047, 9'd120};
          4'd1:    ts = {12'd0, 9'd40};
          4'd2:    ts = {12'd1319, 9'd120};
          4'd3:    ts = {12'd0, 9'd40};
          4'd4:    ts = {12'd1568, 9'd120};
          4'd5:    ts = {12'd0, 9'd40};
          4'd6:    ts = {12'd2093, 9'd250};
          4'd7:    ts = {12'd0, 9'd50};
          default: ts = '0;
        endcase
      end
      default: ts = '0;
    endcase
    return ts;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tone_pattern_sequencer.sv
`default_nettype none

// Buzzer tone-pattern sequencer. A start transfer (req_type 1) launches one of six
// fixed patterns at its first step and drives that step's tone in the same result;
// pattern codes 0 and 7 stop the buzzer. A tick transfer (req_type 0) stands for one
// millisecond and advances the step timer; past the last step the block goes idle
// and raises finished for that one result. Every input transfer yields exactly one
// result transfer. Throughput is one transfer per clock while out_ready is high;
// each item passes the input register, then the result register, and the sequencer
// state advances when an item moves from the input register into the result
// register. in_ready follows out_ready combinationally through the two-entry pipe.
// Register 0 at byte address 0 (mute_enable, bit 0) forces tone_hz to 0 without
// stopping the sequencing; write it only while the block is idle.
module tone_pattern_sequencer (
  input  wire                               clk,
  input  wire                               rst_n,
  // input channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  tps_pkg::in_item_t                 in_data,
  // result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output tps_pkg::out_item_t                out_data,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [tps_pkg::CfgAddrW-1:0]      paddr,
  input  wire  [tps_pkg::CfgDataW-1:0]      pwdata,
  output logic [tps_pkg::CfgDataW-1:0]      prdata,
  output logic                              pready
);

  // input register
  logic                 s1_valid_r;
  tps_pkg::in_item_t    s1_item_r;

  // result register
  logic                 out_valid_r;
  tps_pkg::out_item_t   out_data_r;
  tps_pkg::out_item_t   out_data_nxt;

  // sequencer state
  logic [tps_pkg::PatW-1:0]  active_pattern_r, active_pattern_nxt;
  logic [tps_pkg::StepW-1:0] step_position_r,  step_position_nxt;
  logic [tps_pkg::MsW-1:0]   elapsed_ms_r,     elapsed_ms_nxt;
  logic                      running_r,        running_nxt;

  logic                      mute_enable_r;

  logic                      s1_adv;
  logic                      cfg_wr;
  tps_pkg::tone_step_t       cur_step;
  tps_pkg::tone_step_t       new_step;
  logic [tps_pkg::MsW:0]     elapsed_inc;
  logic [tps_pkg::MsW-1:0]   elapsed_sat;
  logic [tps_pkg::StepW:0]   step_inc;
  logic                      finished;

  // ---------------------------------------------------------------------------
  // Handshake: the input register drains into the result register whenever
  // that one is empty or being taken this cycle.
  // ---------------------------------------------------------------------------
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Configuration port. Index is paddr / 4; only register 0 exists.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tps_pkg::RegMute);

  always_comb begin
    prdata = '0;
    if (paddr[2] == tps_pkg::RegMute) begin
      prdata[0] = mute_enable_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state and result for the item in the input register.
  // ---------------------------------------------------------------------------
  assign cur_step    = tps_pkg::step_lookup(active_pattern_r, step_position_r);
  assign elapsed_inc = {1'b0, elapsed_ms_r} + {{tps_pkg::MsW{1'b0}}, 1'b1};
  // hold at the top of the counter range
  assign elapsed_sat = elapsed_inc[tps_pkg::MsW] ? '1 : elapsed_inc[tps_pkg::MsW-1:0];
  assign step_inc    = {1'b0, step_position_r} + {{tps_pkg::StepW{1'b0}}, 1'b1};

  always_comb begin
    active_pattern_nxt = active_pattern_r;
    step_position_nxt  = step_position_r;
    elapsed_ms_nxt     = elapsed_ms_r;
    running_nxt        = running_r;
    finished           = 1'b0;

    if (s1_item_r.req_type == tps_pkg::ReqStart) begin
      if (s1_item_r.pattern != tps_pkg::PatSilent &&
          s1_item_r.pattern != tps_pkg::PatSilentHi) begin
        // start (or restart) at step 0
        active_pattern_nxt = s1_item_r.pattern;
        step_position_nxt  = '0;
        elapsed_ms_nxt     = '0;
        running_nxt        = 1'b1;
      end else begin
        // silent code stops everything
        active_pattern_nxt = tps_pkg::PatSilent;
        step_position_nxt  = '0;
        elapsed_ms_nxt     = '0;
        running_nxt        = 1'b0;
      end
    end else if (running_r) begin
      elapsed_ms_nxt = elapsed_sat;
      if (elapsed_sat >= cur_step.ms) begin
        elapsed_ms_nxt = '0;
        if (step_inc >= {1'b0, tps_pkg::eff_len(active_pattern_r)}) begin
          // ran past the last step
          active_pattern_nxt = tps_pkg::PatSilent;
          step_position_nxt  = '0;
          running_nxt        = 1'b0;
          finished           = 1'b1;
        end else begin
          step_position_nxt = step_inc[tps_pkg::StepW-1:0];
        end
      end
    end
  end

  // tone of the step the sequencer lands on
  assign new_step = tps_pkg::step_lookup(active_pattern_nxt, step_position_nxt);

  always_comb begin
    out_data_nxt          = '0;
    out_data_nxt.tone_hz  = (running_nxt && !mute_enable_r) ? new_step.hz : '0;
    out_data_nxt.playing  = running_nxt;
    out_data_nxt.finished = finished;
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      active_pattern_r <= tps_pkg::PatSilent;
      step_position_r  <= '0;
      elapsed_ms_r     <= '0;
      running_r        <= 1'b0;
      mute_enable_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r      <= 1'b1;
        active_pattern_r <= active_pattern_nxt;
        step_position_r  <= step_position_nxt;
        elapsed_ms_r     <= elapsed_ms_nxt;
        running_r        <= running_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        mute_enable_r <= pwdata[0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tps_chk.sv
`default_nettype none

`include "assert_macros.svh"

module tps_chk (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input tps_pkg::in_item_t            in_data,
  input wire                          out_valid,
  input wire                          out_ready,
  input tps_pkg::out_item_t           out_data,
  input wire                          pready
);

  // an offered input holds until taken
  `ASSERT_CLK(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_data), "input changed while stalled")

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // completion always leaves the block idle
  `ASSERT_CLK(a_fin_idle, clk, rst_n, out_valid && out_data.finished |-> !out_data.playing, "finished while still playing")

  // a tone is only driven while a pattern plays
  `ASSERT_CLK(a_tone_play, clk, rst_n, out_valid && out_data.tone_hz != 0 |-> out_data.playing, "tone without a running pattern")

  // reset empties the result register
  `ASSERT_CLK_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid && pready, "result valid after reset")

endmodule

bind tone_pattern_sequencer tps_chk u_tps_chk (.*);

`default_nettype wire

// File: tb/tone_pattern_sequencer_tb.sv
`timescale 1ns / 100ps

module tone_pattern_sequencer_tb;

  // Settle time after the last result before touching config or ending:
  // two pipe stages plus margin.
  localparam int LatCycles = 4;
  // Receiver hold-off long enough to back the two-entry pipe up into in_ready.
  localparam int LongHold = 400;

  localparam logic [tps_pkg::CfgAddrW-1:0] MuteAddr =
    tps_pkg::CfgAddrW'(4 * tps_pkg::RegMute);

  // Step tables, row = pattern code - 1, column = step. Unused steps are zero.
  localparam logic [0:5][0:11][tps_pkg::HzW-1:0] SeqHz = {
    {12'd1047, 12'd0, {10{12'd0}}},
    {12'd1047, 12'd0, 12'd1047, 12'd0, {8{12'd0}}},
    {12'd400, 12'd0, {10{12'd0}}},
    {12'd1000, 12'd0, 12'd1500, 12'd0, 12'd1000, 12'd0,
     12'd1500, 12'd0, 12'd1000, 12'd0, 12'd1500, 12'd0},
    {12'd1047, 12'd0, 12'd1319, 12'd0, 12'd1568, 12'd0, {6{12'd0}}},
    {12'd1047, 12'd0, 12'd1319, 12'd0, 12'd1568, 12'd0,
     12'd2093, 12'd0, {4{12'd0}}}
  };
  localparam logic [0:5][0:11][tps_pkg::MsW-1:0] SeqMs = {
    {9'd100, 9'd50, {10{9'd0}}},
    {9'd100, 9'd80, 9'd100, 9'd50, {8{9'd0}}},
    {9'd300, 9'd50, {10{9'd0}}},
    {9'd80, 9'd40, 9'd80, 9'd40, 9'd80, 9'd40,
     9'd80, 9'd40, 9'd80, 9'd40, 9'd80, 9'd50},
    {9'd150, 9'd50, 9'd150, 9'd50, 9'd300, 9'd50, {6{9'd0}}},
    {9'd120, 9'd40, 9'd120, 9'd40, 9'd120, 9'd40,
     9'd250, 9'd50, {4{9'd0}}}
  };
  localparam logic [0:5][tps_pkg::StepW-1:0] SeqLen =
    {4'd2, 4'd4, 4'd2, 4'd12, 4'd6, 4'd8};

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  tps_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tps_pkg::out_item_t out_data;

  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [tps_pkg::CfgAddrW-1:0] paddr = '0;
  logic [tps_pkg::CfgDataW-1:0] pwdata = '0;
  logic [tps_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  tone_pattern_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Requests waiting to be offered, and tone results owed by the block.
  tps_pkg::in_item_t  pending_reqs[$];
  tps_pkg::out_item_t tone_due[$];

  int mismatch_cnt  = 0;
  int results_seen  = 0;
  int hold_requests = 0;  // bumped by the sequence to ask for one long receiver stall
  int hold_served   = 0;

  // Shadow of the sequencer, advanced once per accepted input transfer.
  logic [tps_pkg::PatW-1:0]  seq_pat  = tps_pkg::PatSilent;
  logic [tps_pkg::StepW-1:0] seq_step = '0;
  logic [tps_pkg::MsW-1:0]   seq_ms   = '0;
  logic                      seq_run  = 1'b0;
  logic                      mute_copy = 1'b0;

  // Stimulus bookkeeping: which patterns have been ticked all the way out.
  logic [5:0]               played_out = '0;
  logic [tps_pkg::PatW-1:0] next_full  = tps_pkg::PatShort;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic int steps_in(input logic [tps_pkg::PatW-1:0] pat);
    int n;
    n = int'(SeqLen[int'(pat) - 1]);
    return (n > int'(tps_pkg::MaxSteps)) ? int'(tps_pkg::MaxSteps) : n;
  endfunction

  // Ticks needed to run a pattern off its end.
  function automatic int seq_total(input logic [tps_pkg::PatW-1:0] pat);
    int sum;
    sum = 0;
    for (int s = 0; s < steps_in(pat); s++) begin
      sum += int'(SeqMs[int'(pat) - 1][s]);
    end
    return sum;
  endfunction

  function automatic void seq_stop();
    seq_run  = 1'b0;
    seq_pat  = tps_pkg::PatSilent;
    seq_step = '0;
    seq_ms   = '0;
  endfunction

  // Next tone result for one request; updates the shadow state.
  function automatic tps_pkg::out_item_t predict_tone(input tps_pkg::in_item_t req);
    tps_pkg::out_item_t res;
    logic               fin;
    int                 row;
    fin = 1'b0;
    if (req.req_type == tps_pkg::ReqStart) begin
      // codes 0 and 7 stop; anything else (re)starts at step 0
      if (req.pattern >= tps_pkg::PatShort && req.pattern <= tps_pkg::PatSuccess) begin
        seq_pat  = req.pattern;
        seq_step = '0;
        seq_ms   = '0;
        seq_run  = 1'b1;
      end else begin
        seq_stop();
      end
    end else if (seq_run) begin
      row = int'(seq_pat) - 1;
      if (seq_ms != '1) begin
        seq_ms = seq_ms + 1'b1;  // saturating ms counter
      end
      if (seq_ms >= SeqMs[row][seq_step]) begin
        seq_ms = '0;
        if (int'(seq_step) + 1 >= steps_in(seq_pat)) begin
          seq_stop();
          fin = 1'b1;
        end else begin
          seq_step = seq_step + 1'b1;
        end
      end
    end
    // ticks while idle fall through: all zeros
    res.tone_hz = '0;
    if (seq_run && !mute_copy) begin
      res.tone_hz = SeqHz[int'(seq_pat) - 1][seq_step];
    end
    res.playing  = seq_run;
    res.finished = fin;
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_req(input logic req, input logic [tps_pkg::PatW-1:0] pat);
    tps_pkg::in_item_t it;
    it.req_type = req;
    it.pattern  = pat;
    pending_reqs.push_back(it);
  endtask

  // Mostly start + tick runs with random length, some run to the end;
  // the rest is loose noise and early stops.
  task automatic gen_sequences(input int quota, input bit need_all);
    int                       made;
    int                       ticks;
    int                       span;
    int                       n;
    bit                       full;
    logic [tps_pkg::PatW-1:0] pat;
    made = 0;
    while ((made < quota || (need_all && played_out != '1)) && made < 20000) begin
      if ($urandom_range(0, 99) < 10) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          push_req(1'($urandom_range(0, 1)), tps_pkg::PatW'($urandom_range(0, 7)));
        end
        made += n;
      end else begin
        full = ($urandom_range(0, 99) < 30);
        if (full) begin
          // rotate so every pattern gets played out
          pat = next_full;
          next_full = (next_full == tps_pkg::PatSuccess) ? tps_pkg::PatShort
                                                         : next_full + 1'b1;
        end else begin
          pat = tps_pkg::PatW'($urandom_range(tps_pkg::PatShort, tps_pkg::PatSuccess));
        end
        span  = seq_total(pat);
        ticks = full ? span + $urandom_range(0, 3) : $urandom_range(0, 150);
        if (ticks >= span) begin
          played_out[int'(pat) - 1] = 1'b1;
        end
        push_req(tps_pkg::ReqStart, pat);
        repeat (ticks) begin
          push_req(tps_pkg::ReqTick, tps_pkg::PatW'($urandom_range(0, 7)));
        end
        made += ticks + 1;
        if ($urandom_range(0, 4) == 0) begin
          push_req(tps_pkg::ReqStart,
                   $urandom_range(0, 1) ? tps_pkg::PatSilent : tps_pkg::PatSilentHi);
          made++;
        end
      end
    end
  endtask

  // Sender pause: hold off until everything offered has come back.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || tone_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (LatCycles) @(posedge clk);
  endtask

  // Write mute over the config port, then read it back.
  task automatic set_mute(input logic val);
    logic [tps_pkg::CfgDataW-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MuteAddr;
    pwdata  <= tps_pkg::CfgDataW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mute_copy = val;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[0] !== val) begin
      flag_mismatch($sformatf("mute readback got %0d want %0d", got[0], val));
    end
  endtask

  // Sender: offers the next pending request after its gap; prediction is done
  // on the transfer edge so it stays in acceptance order.
  int snd_gap  = 0;
  int snd_calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tone_due.push_back(predict_tone(in_data));
      end
      if (!in_valid || in_ready) begin
        if (snd_gap > 0) begin
          snd_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (snd_calm > 0) begin
            snd_calm--;
            snd_gap = 0;
          end else begin
            snd_gap = pick_gap();
            if ($urandom_range(0, 99) == 0) snd_calm = $urandom_range(50, 200);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure after each transfer, plus the long hold-off
  // when the sequence asks for one.
  int rcv_gap   = 0;
  int rcv_calm  = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LongHold;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rcv_calm > 0) begin
          rcv_calm--;
          rcv_gap = 0;
        end else begin
          rcv_gap = pick_gap();
          if ($urandom_range(0, 99) == 0) rcv_calm = $urandom_range(50, 200);
        end
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: every result transfer against the oldest expectation.
  always @(posedge clk) begin : tone_check
    tps_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tone_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing expected", results_seen));
      end else begin
        want = tone_due.pop_front();
        if (out_data.tone_hz !== want.tone_hz) begin
          flag_mismatch($sformatf("result %0d tone_hz got %0d want %0d",
                                  results_seen, out_data.tone_hz, want.tone_hz));
        end
        if (out_data.playing !== want.playing) begin
          flag_mismatch($sformatf("result %0d playing got %0b want %0b",
                                  results_seen, out_data.playing, want.playing));
        end
        if (out_data.finished !== want.finished) begin
          flag_mismatch($sformatf("result %0d finished got %0b want %0b",
                                  results_seen, out_data.finished, want.finished));
        end
      end
      results_seen++;
    end
  end

  // Sequence: directed corners, then three random phases with mute off, on,
  // off again. Config only changes with the pipe drained.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    set_mute(1'b0);

    // tick while idle, silent code, one start per pattern
    push_req(tps_pkg::ReqTick, tps_pkg::PatSilentHi);
    push_req(tps_pkg::ReqStart, tps_pkg::PatSilent);
    push_req(tps_pkg::ReqTick, tps_pkg::PatSilent);
    for (int p = tps_pkg::PatShort; p <= tps_pkg::PatSuccess; p++) begin
      push_req(tps_pkg::ReqStart, tps_pkg::PatW'(p));
      push_req(tps_pkg::ReqTick, tps_pkg::PatW'(p));
    end
    // restart mid-pattern, then the high silent code stopping a running one
    push_req(tps_pkg::ReqStart, tps_pkg::PatUrgent);
    push_req(tps_pkg::ReqTick, tps_pkg::PatSilentHi);
    push_req(tps_pkg::ReqStart, tps_pkg::PatShort);
    push_req(tps_pkg::ReqTick, tps_pkg::PatSilent);
    push_req(tps_pkg::ReqStart, tps_pkg::PatSilentHi);
    push_req(tps_pkg::ReqTick, tps_pkg::PatSilentHi);
    wait_drained();

    // receiver stalls long while the sender keeps offering
    gen_sequences(700, 1'b0);
    hold_requests++;
    wait_drained();

    set_mute(1'b1);
    gen_sequences(500, 1'b0);
    wait_drained();

    set_mute(1'b0);
    gen_sequences(400, 1'b0);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tps_pkg.sv
rtl/core/tone_pattern_sequencer.sv
rtl/core/tps_chk.sv
tb/tone_pattern_sequencer_tb.sv
